@@ design/pfc_pkg.sv @@
`timescale 1ns / 1ps
package pfc_pkg;

  localparam int DefMaxVerts = 16;
  localparam int DefFracBits = 16;
  localparam int FieldW      = 32;
  localparam int VtxW        = 6 * FieldW;

  typedef struct packed {
    logic signed [FieldW-1:0] x;
    logic signed [FieldW-1:0] y;
    logic signed [FieldW-1:0] z;
    logic signed [FieldW-1:0] u;
    logic signed [FieldW-1:0] v;
    logic signed [FieldW-1:0] w;
  } vtx_t;

  typedef enum logic [1:0] {PL_LEFT, PL_RIGHT, PL_TOP, PL_BOTTOM} plane_t;

  typedef enum logic [2:0] {FLD_X, FLD_Y, FLD_Z, FLD_U, FLD_V, FLD_W} field_t;

  typedef enum logic [1:0] {WS_IN, WS_PREV, WS_CROSS} wsel_t;

  // controller to datapath
  typedef struct packed {
    logic   we_a;
    logic   we_b;
    wsel_t  wsel;
    logic   src_b;
    logic   ld_prev;
    logic   ld_cur;
    logic   adv;
    logic   div_start;
    logic   mul_en;
    logic   add_en;
    field_t fld;
    plane_t plane;
    logic   out_empty;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic da_in;
    logic db_in;
    logic div_done;
  } dp_sts_t;

  function automatic logic signed [FieldW:0] plane_dist(vtx_t p, plane_t pl);
    logic signed [FieldW:0] x, y, z;
    x = {p.x[FieldW-1], p.x};
    y = {p.y[FieldW-1], p.y};
    z = {p.z[FieldW-1], p.z};
    case (pl)
      PL_LEFT:  plane_dist = x + z;
      PL_RIGHT: plane_dist = z - x;
      PL_TOP:   plane_dist = y + z;
      default:  plane_dist = z - y;
    endcase
  endfunction

  function automatic logic signed [FieldW-1:0] field_of(vtx_t p, field_t f);
    case (f)
      FLD_X:   field_of = p.x;
      FLD_Y:   field_of = p.y;
      FLD_Z:   field_of = p.z;
      FLD_U:   field_of = p.u;
      FLD_V:   field_of = p.v;
      default: field_of = p.w;
    endcase
  endfunction

endpackage

@@ design/pfc_ram.sv @@
`timescale 1ns / 1ps
module pfc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/pfc_datapath.sv @@
`timescale 1ns / 1ps
module pfc_datapath #(
  parameter int MAX_VERTS = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pfc_pkg::dp_cmd_t               cmd,
  input  logic [$clog2(MAX_VERTS)-1:0]   wr_addr,
  input  logic [$clog2(MAX_VERTS)-1:0]   rd_addr,
  input  logic signed [pfc_pkg::FieldW-1:0] in_x,
  input  logic signed [pfc_pkg::FieldW-1:0] in_y,
  input  logic signed [pfc_pkg::FieldW-1:0] in_z,
  input  logic signed [pfc_pkg::FieldW-1:0] in_u,
  input  logic signed [pfc_pkg::FieldW-1:0] in_v,
  input  logic signed [pfc_pkg::FieldW-1:0] in_w,
  output pfc_pkg::dp_sts_t               sts,
  output logic signed [pfc_pkg::FieldW-1:0] out_x,
  output logic signed [pfc_pkg::FieldW-1:0] out_y,
  output logic signed [pfc_pkg::FieldW-1:0] out_z,
  output logic signed [pfc_pkg::FieldW-1:0] out_u,
  output logic signed [pfc_pkg::FieldW-1:0] out_v,
  output logic signed [pfc_pkg::FieldW-1:0] out_w
);
  import pfc_pkg::*;

  localparam int QW   = FRAC_BITS + 1;
  localparam int MW   = FieldW + 1;
  localparam int DW   = FieldW + 2;
  localparam int RW   = FieldW + 3;
  localparam int PW   = MW + QW + 1;
  localparam int CNTW = $clog2(QW + 1);

  vtx_t in_vtx, wdata, rdata_a, rdata_b, src_vtx;
  vtx_t prev_r, cur_r, cross_r;
  logic [VtxW-1:0] rd_a_raw, rd_b_raw;

  logic signed [MW-1:0] da, db;
  logic [MW-1:0]        mag_a, mag_b;
  logic [DW-1:0]        den;

  logic [RW-1:0]   rem_r, rem_sub;
  logic [DW-1:0]   den_r;
  logic [QW-1:0]   q_r;
  logic [CNTW-1:0] cnt_r;
  logic            dbusy_r, ge;

  logic signed [FieldW-1:0] p_f, q_f, res;
  logic signed [MW-1:0]     diff;
  logic signed [PW-1:0]     prod_r, sum;

  assign in_vtx = '{x: in_x, y: in_y, z: in_z, u: in_u, v: in_v, w: in_w};

  always_comb begin
    case (cmd.wsel)
      WS_IN:    wdata = in_vtx;
      WS_CROSS: wdata = cross_r;
      default:  wdata = prev_r;
    endcase
  end

  pfc_ram #(.WIDTH(VtxW), .DEPTH(MAX_VERTS)) u_ram_a (
    .clk(clk), .we(cmd.we_a), .waddr(wr_addr), .wdata(wdata),
    .raddr(rd_addr), .rdata(rd_a_raw)
  );

  pfc_ram #(.WIDTH(VtxW), .DEPTH(MAX_VERTS)) u_ram_b (
    .clk(clk), .we(cmd.we_b), .waddr(wr_addr), .wdata(wdata),
    .raddr(rd_addr), .rdata(rd_b_raw)
  );

  assign rdata_a = vtx_t'(rd_a_raw);
  assign rdata_b = vtx_t'(rd_b_raw);
  assign src_vtx = cmd.src_b ? rdata_b : rdata_a;

  assign da    = plane_dist(prev_r, cmd.plane);
  assign db    = plane_dist(cur_r, cmd.plane);
  assign mag_a = da[MW-1] ? MW'(-da) : MW'(da);
  assign mag_b = db[MW-1] ? MW'(-db) : MW'(db);
  assign den   = {1'b0, mag_a} + {1'b0, mag_b};

  assign sts.da_in    = ~da[MW-1];
  assign sts.db_in    = ~db[MW-1];
  assign sts.div_done = ~dbusy_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_prev) begin
      prev_r <= src_vtx;
    end else if (cmd.adv) begin
      prev_r <= cur_r;
    end
    if (cmd.ld_cur) begin
      cur_r <= src_vtx;
    end
  end

  // restoring divide, one quotient bit a cycle: t = |da| * 2^F / (|da| + |db|)
  assign ge      = rem_r >= {1'b0, den_r};
  assign rem_sub = ge ? (rem_r - {1'b0, den_r}) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dbusy_r <= 1'b1;
    end else if (dbusy_r && cnt_r == CNTW'(1)) begin
      dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem_r <= RW'(mag_a);
      den_r <= den;
      q_r   <= '0;
      cnt_r <= CNTW'(QW);
    end else if (dbusy_r) begin
      rem_r <= {rem_sub[RW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], ge};
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  // interpolate one field at a time, multiply then add: p + floor((q - p) * t / 2^F)
  assign p_f  = field_of(prev_r, cmd.fld);
  assign q_f  = field_of(cur_r, cmd.fld);
  assign diff = {q_f[FieldW-1], q_f} - {p_f[FieldW-1], p_f};
  assign sum  = PW'(p_f) + (prod_r >>> FRAC_BITS);
  assign res  = sum[FieldW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= diff * $signed({1'b0, q_r});
    end
    if (cmd.add_en) begin
      case (cmd.fld)
        FLD_X:   cross_r.x <= res;
        FLD_Y:   cross_r.y <= res;
        FLD_Z:   cross_r.z <= res;
        FLD_U:   cross_r.u <= res;
        FLD_V:   cross_r.v <= res;
        default: cross_r.w <= res;
      endcase
    end
  end

  assign out_x = cmd.out_empty ? '0 : rdata_a.x;
  assign out_y = cmd.out_empty ? '0 : rdata_a.y;
  assign out_z = cmd.out_empty ? '0 : rdata_a.z;
  assign out_u = cmd.out_empty ? '0 : rdata_a.u;
  assign out_v = cmd.out_empty ? '0 : rdata_a.v;
  assign out_w = cmd.out_empty ? '0 : rdata_a.w;

endmodule

@@ design/pfc_ctrl.sv @@
`timescale 1ns / 1ps
module pfc_ctrl #(
  parameter int MAX_VERTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         in_last,
  input  pfc_pkg::dp_sts_t             sts,
  output pfc_pkg::dp_cmd_t             cmd,
  output logic [$clog2(MAX_VERTS)-1:0] wr_addr,
  output logic [$clog2(MAX_VERTS)-1:0] rd_addr,
  output logic                         busy,
  output logic                         out_strobe,
  output logic                         out_vertex_valid,
  output logic                         out_last,
  output logic                         out_overflow
);
  import pfc_pkg::*;

  localparam int AW = $clog2(MAX_VERTS);
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_STAGE, S_RD_PREV, S_LD_PREV, S_RD_CUR, S_LD_CUR, S_EMIT, S_CROSS,
    S_DIV, S_MUL, S_ADD, S_WR_X, S_NEXT, S_OUT_CHK, S_OUT_RD, S_OUT, S_EMPTY
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, n_r, n_nxt, r_r, r_nxt;
  logic [AW-1:0] b_r, b_nxt;
  plane_t        plane_r, plane_nxt;
  field_t        fld_r, fld_nxt;
  logic          ovf_r, ovf_nxt;
  logic          room, at_end;

  assign room   = r_r < CW'(MAX_VERTS);
  assign at_end = CW'(b_r) == (n_r - CW'(1));

  assign busy         = state_r != S_IDLE;
  assign out_overflow = ovf_r;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    n_nxt     = n_r;
    r_nxt     = r_r;
    b_nxt     = b_r;
    plane_nxt = plane_r;
    fld_nxt   = fld_r;
    ovf_nxt   = ovf_r;

    cmd       = '0;
    cmd.wsel  = WS_PREV;
    cmd.plane = plane_r;
    cmd.src_b = plane_r[0];
    cmd.fld   = fld_r;
    wr_addr   = r_r[AW-1:0];
    rd_addr   = b_r;

    out_strobe       = 1'b0;
    out_vertex_valid = 1'b0;
    out_last         = 1'b0;

    case (state_r)
      S_IDLE: begin
        cmd.wsel = WS_IN;
        wr_addr  = count_r[AW-1:0];
        if (start) begin
          if (count_r < CW'(MAX_VERTS)) begin
            cmd.we_a  = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt     = (count_r < CW'(MAX_VERTS)) ? count_r + CW'(1) : count_r;
            plane_nxt = PL_LEFT;
            state_nxt = S_STAGE;
          end
        end
      end
      S_STAGE: begin
        r_nxt = '0;
        b_nxt = '0;
        state_nxt = (n_r < CW'(3)) ? S_EMPTY : S_RD_PREV;
      end
      S_RD_PREV: begin
        rd_addr   = AW'(n_r - CW'(1));
        state_nxt = S_LD_PREV;
      end
      S_LD_PREV: begin
        cmd.ld_prev = 1'b1;
        state_nxt   = S_RD_CUR;
      end
      S_RD_CUR: begin
        state_nxt = S_LD_CUR;
      end
      S_LD_CUR: begin
        cmd.ld_cur = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (sts.da_in) begin
          if (room) begin
            cmd.we_a = plane_r[0];
            cmd.we_b = ~plane_r[0];
            r_nxt    = r_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        state_nxt = (sts.da_in != sts.db_in) ? S_CROSS : S_NEXT;
      end
      S_CROSS: begin
        if (room) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          ovf_nxt   = 1'b1;
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          fld_nxt   = FLD_X;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.add_en = 1'b1;
        if (fld_r == FLD_W) begin
          state_nxt = S_WR_X;
        end else begin
          fld_nxt   = field_t'(fld_r + 3'd1);
          state_nxt = S_MUL;
        end
      end
      S_WR_X: begin
        cmd.wsel  = WS_CROSS;
        cmd.we_a  = plane_r[0];
        cmd.we_b  = ~plane_r[0];
        r_nxt     = r_r + CW'(1);
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.adv = 1'b1;
        if (at_end) begin
          n_nxt = r_r;
          if (plane_r == PL_BOTTOM) begin
            state_nxt = S_OUT_CHK;
          end else begin
            plane_nxt = plane_t'(plane_r + 2'd1);
            state_nxt = S_STAGE;
          end
        end else begin
          b_nxt     = b_r + AW'(1);
          state_nxt = S_RD_CUR;
        end
      end
      S_OUT_CHK: begin
        b_nxt     = '0;
        state_nxt = (n_r < CW'(3)) ? S_EMPTY : S_OUT_RD;
      end
      S_OUT_RD: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_strobe       = 1'b1;
        out_vertex_valid = 1'b1;
        out_last         = at_end;
        if (at_end) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          b_nxt     = b_r + AW'(1);
          state_nxt = S_OUT_RD;
        end
      end
      S_EMPTY: begin
        cmd.out_empty = 1'b1;
        out_strobe    = 1'b1;
        out_last      = 1'b1;
        count_nxt     = '0;
        ovf_nxt       = 1'b0;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      n_r     <= '0;
      r_r     <= '0;
      b_r     <= '0;
      plane_r <= PL_LEFT;
      fld_r   <= FLD_X;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      n_r     <= n_nxt;
      r_r     <= r_nxt;
      b_r     <= b_nxt;
      plane_r <= plane_nxt;
      fld_r   <= fld_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

@@ design/polygon_frustum_clipper.sv @@
`timescale 1ns / 1ps
// Polygon clipper against the left, right, top and bottom frustum planes.
// Input: drive start with one vertex (in_x .. in_w, in_last) while busy is
// low; the request is taken at that edge. A vertex without in_last leaves
// busy low, so vertices may stream back to back. Vertices past MAX_VERTS
// are dropped and flagged in out_overflow.
// The vertex with in_last starts clipping; busy stays high until the last
// result is out. Each plane pass walks every edge of the polygon; an edge
// that crosses the plane also runs the bit-serial divider, then one shared
// multiplier over six fields; a polygon that clips empty skips the
// remaining passes.
// Output: one result per clipped vertex, each on the out_ ports for one cycle
// with out_strobe high, never back to back; out_last marks the final one. An
// empty polygon gives one result with out_vertex_valid low. The receiver
// cannot stall: results must be taken as they appear.
// Reset clears the vertex count, overflow flag and controller; the vertex
// memories are not cleared.
module polygon_frustum_clipper #(
  parameter int MAX_VERTS = pfc_pkg::DefMaxVerts,
  parameter int FRAC_BITS = pfc_pkg::DefFracBits
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [pfc_pkg::FieldW-1:0] in_x,
  input  logic signed [pfc_pkg::FieldW-1:0] in_y,
  input  logic signed [pfc_pkg::FieldW-1:0] in_z,
  input  logic signed [pfc_pkg::FieldW-1:0] in_u,
  input  logic signed [pfc_pkg::FieldW-1:0] in_v,
  input  logic signed [pfc_pkg::FieldW-1:0] in_w,
  input  logic                              in_last,
  output logic                              out_strobe,
  output logic signed [pfc_pkg::FieldW-1:0] out_x,
  output logic signed [pfc_pkg::FieldW-1:0] out_y,
  output logic signed [pfc_pkg::FieldW-1:0] out_z,
  output logic signed [pfc_pkg::FieldW-1:0] out_u,
  output logic signed [pfc_pkg::FieldW-1:0] out_v,
  output logic signed [pfc_pkg::FieldW-1:0] out_w,
  output logic                              out_vertex_valid,
  output logic                              out_last,
  output logic                              out_overflow
);
  import pfc_pkg::*;

  localparam int AW = $clog2(MAX_VERTS);

  dp_cmd_t       cmd;
  dp_sts_t       sts;
  logic [AW-1:0] wr_addr, rd_addr;

  pfc_ctrl #(.MAX_VERTS(MAX_VERTS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_last(in_last),
    .sts(sts), .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr),
    .busy(busy), .out_strobe(out_strobe), .out_vertex_valid(out_vertex_valid),
    .out_last(out_last), .out_overflow(out_overflow)
  );

  pfc_datapath #(.MAX_VERTS(MAX_VERTS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .wr_addr(wr_addr), .rd_addr(rd_addr),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_u(in_u), .in_v(in_v), .in_w(in_w),
    .sts(sts),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_u(out_u), .out_v(out_v), .out_w(out_w)
  );

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result without busy");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_vertex_valid) |-> out_last) else $error("empty not last");

  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last) |=> !out_strobe) else $error("results too close");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_last)) else $error("busy without last vertex");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |=> !busy) else $error("busy after last result");

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import pfc_pkg::*;

  localparam int NVERT = 16;
  localparam int FRACB = 16;
  localparam int NUM_ITEMS = 160;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] x, y, z, u, v, w;
    logic last;
  } vin_t;

  typedef struct {
    logic signed [31:0] x, y, z, u, v, w;
    logic valid, last, ovf;
  } vout_t;

  typedef longint fv_t[6];

  logic clk, rst_n, start, busy, in_last;
  logic signed [31:0] in_x, in_y, in_z, in_u, in_v, in_w;
  logic out_strobe, out_vertex_valid, out_last, out_overflow;
  logic signed [31:0] out_x, out_y, out_z, out_u, out_v, out_w;

  polygon_frustum_clipper dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x(in_x), .in_y(in_y), .in_z(in_z), .in_u(in_u), .in_v(in_v), .in_w(in_w),
    .in_last(in_last), .out_strobe(out_strobe), .out_x(out_x), .out_y(out_y),
    .out_z(out_z), .out_u(out_u), .out_v(out_v), .out_w(out_w),
    .out_vertex_valid(out_vertex_valid), .out_last(out_last),
    .out_overflow(out_overflow)
  );

  vin_t  pending_verts[$];
  vout_t clipped_verts[$];
  fv_t   poly_store[NVERT];
  int    poly_count;
  bit    poly_ovf;
  bit    failed;
  bit    stim_done;
  longint cycles;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_frac(longint p);
    return p >>> FRACB;
  endfunction

  function automatic longint dist_of(fv_t p, plane_t pl);
    case (pl)
      PL_LEFT:  return p[0] + p[2];
      PL_RIGHT: return p[2] - p[0];
      PL_TOP:   return p[1] + p[2];
      default:  return p[2] - p[1];
    endcase
  endfunction

  // one Sutherland-Hodgman pass; returns vertex count of dst
  function automatic int clip_plane(fv_t src[NVERT], int n, ref fv_t dst[NVERT],
                                    input plane_t pl);
    int r, a;
    longint da, db, t;
    r = 0;
    if (n < 3) return 0;
    a = n - 1;
    for (int b = 0; b < n; b++) begin
      da = dist_of(src[a], pl);
      db = dist_of(src[b], pl);
      if (da >= 0) begin
        if (r < NVERT) begin
          dst[r] = src[a];
          r++;
        end else poly_ovf = 1;
      end
      if ((da >= 0) != (db >= 0)) begin
        if (r < NVERT) begin
          t = (da * (64'sd1 <<< FRACB)) / (da - db);
          for (int k = 0; k < 6; k++)
            dst[r][k] = src[a][k] + floor_frac((src[b][k] - src[a][k]) * t);
          r++;
        end else poly_ovf = 1;
      end
      a = b;
    end
    return r;
  endfunction

  task automatic predict_vertex(vin_t vi);
    fv_t ping[NVERT], pong[NVERT];
    int n;
    vout_t o;
    if (poly_count < NVERT) begin
      poly_store[poly_count] = '{vi.x, vi.y, vi.z, vi.u, vi.v, vi.w};
      poly_count++;
    end else poly_ovf = 1;
    if (!vi.last) return;
    for (int i = 0; i < poly_count; i++) ping[i] = poly_store[i];
    n = clip_plane(ping, poly_count, pong, PL_LEFT);
    n = clip_plane(pong, n, ping, PL_RIGHT);
    n = clip_plane(ping, n, pong, PL_TOP);
    n = clip_plane(pong, n, ping, PL_BOTTOM);
    if (n < 3) begin
      o = '{0, 0, 0, 0, 0, 0, 1'b0, 1'b1, poly_ovf};
      clipped_verts.push_back(o);
    end else begin
      for (int i = 0; i < n; i++) begin
        o.x = 32'(ping[i][0]); o.y = 32'(ping[i][1]); o.z = 32'(ping[i][2]);
        o.u = 32'(ping[i][3]); o.v = 32'(ping[i][4]); o.w = 32'(ping[i][5]);
        o.valid = 1; o.last = (i == n - 1); o.ovf = poly_ovf;
        clipped_verts.push_back(o);
      end
    end
    poly_count = 0;
    poly_ovf = 0;
  endtask

  function automatic logic [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endcase
  endfunction

  task automatic add_vertex(logic [31:0] x, y, z, logic last);
    vin_t v;
    v.x = x; v.y = y; v.z = z;
    v.u = $urandom; v.v = $urandom; v.w = $urandom;
    v.last = last;
    pending_verts.push_back(v);
  endtask

  task automatic add_polygon(int nv, bit wide);
    for (int i = 0; i < nv; i++)
      if (wide) add_vertex(rnd_word(), rnd_word(), rnd_word(), i == nv - 1);
      else add_vertex($signed($urandom_range(0, 6 << 16)) - (3 << 16),
                      $signed($urandom_range(0, 6 << 16)) - (3 << 16),
                      $urandom_range(0, 4 << 16), i == nv - 1);
  endtask

  int gen_count;
  initial begin
    // fully inside triangle
    add_vertex(0, 0, 32'h0001_0000, 0);
    add_vertex(32'h0000_8000, 0, 32'h0001_0000, 0);
    add_vertex(0, 32'h0000_8000, 32'h0001_0000, 1);
    // crossing every plane
    add_vertex(32'hfffe_0000, 32'hfffe_0000, 32'h0001_0000, 0);
    add_vertex(32'h0002_0000, 32'hfffe_0000, 32'h0001_0000, 0);
    add_vertex(32'h0002_0000, 32'h0002_0000, 32'h0001_0000, 0);
    add_vertex(32'hfffe_0000, 32'h0002_0000, 32'h0001_0000, 1);
    // two vertices, then a single one: empty polygon
    add_vertex(0, 0, 32'h0001_0000, 0);
    add_vertex(0, 0, 32'h0001_0000, 1);
    add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);
    // extremes of the fields
    add_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
    add_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    add_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1);
    // random polygons, then store full: 18 random vertices, two dropped
    gen_count = 13;
    while (gen_count < NUM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin add_polygon(NVERT + $urandom_range(1, 3), 0); end
        1: begin add_polygon($urandom_range(1, 6), 1); end
        default: add_polygon($urandom_range(3, 8), 0);
      endcase
      gen_count = pending_verts.size();
    end
    add_polygon(NVERT + 2, 0);
  end

  int drv_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
      drv_gap <= 0;
      stim_done <= 0;
    end else begin
      if (start && !busy) begin
        predict_vertex(pending_verts.pop_front());
      end
      if (start && busy) begin
        // hold the request
      end else if (pending_verts.size() == 0) begin
        start <= 0;
        stim_done <= 1;
      end else if (drv_gap > 0) begin
        start <= 0;
        drv_gap <= drv_gap - 1;
      end else begin
        if (pending_verts.size() > 30 && $urandom_range(0, 5) == 0 && !start) begin
          drv_gap <= $urandom_range(1, 17) - 1;
          start <= 0;
        end else begin
          start   <= 1;
          in_x    <= pending_verts[0].x;
          in_y    <= pending_verts[0].y;
          in_z    <= pending_verts[0].z;
          in_u    <= pending_verts[0].u;
          in_v    <= pending_verts[0].v;
          in_w    <= pending_verts[0].w;
          in_last <= pending_verts[0].last;
        end
      end
    end
  end

  always @(posedge clk) begin
    vout_t e;
    if (rst_n && out_strobe) begin
      if (clipped_verts.size() == 0) begin
        $display("%0t: unexpected result x=%h", $time, out_x);
        failed = 1;
      end else begin
        e = clipped_verts.pop_front();
        if ({out_x, out_y, out_z, out_u, out_v, out_w, out_vertex_valid, out_last,
             out_overflow} !== {e.x, e.y, e.z, e.u, e.v, e.w, e.valid, e.last, e.ovf}) begin
          $display("%0t: mismatch expected %h %h %h %h %h %h v%b l%b o%b", $time,
                   e.x, e.y, e.z, e.u, e.v, e.w, e.valid, e.last, e.ovf);
          $display("%0t:          actual %h %h %h %h %h %h v%b l%b o%b", $time,
                   out_x, out_y, out_z, out_u, out_v, out_w, out_vertex_valid,
                   out_last, out_overflow);
          failed = 1;
        end
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    failed = 0;
    poly_count = 0;
    poly_ovf = 0;
    rst_n = 0;
    start = 0;
    {in_x, in_y, in_z, in_u, in_v, in_w, in_last} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    wait (stim_done && !start && !busy && clipped_verts.size() == 0);
    repeat (50) @(posedge clk);
    if (!failed && clipped_verts.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

@@ files.f @@
design/pfc_pkg.sv
design/pfc_ram.sv
design/pfc_datapath.sv
design/pfc_ctrl.sv
design/polygon_frustum_clipper.sv
tb/tb.sv
